// ===== hdl/cku_pkg.sv =====
// Package for the C keyword upper-casing filter: payload structs, lexer modes,
// result kinds, character constants and the keyword table.
// No dependencies.
package cku_pkg;

  localparam int KW_NUM   = 32;
  localparam int KW_CHARS = 8;

  typedef enum logic [2:0] {
    MODE_TEXT,
    MODE_WORD,
    MODE_PASS,
    MODE_SLASH,
    MODE_LINE,
    MODE_BLOCK,
    MODE_BSTAR
  } lex_mode_t;

  localparam logic [1:0] KIND_CHAR     = 2'd0;
  localparam logic [1:0] KIND_END_OK   = 2'd1;
  localparam logic [1:0] KIND_END_OPEN = 2'd2;

  localparam logic [7:0] CH_SLASH    = 8'h2f;
  localparam logic [7:0] CH_STAR     = 8'h2a;
  localparam logic [7:0] CH_NEWLINE  = 8'h0a;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_out;
    logic       last;
  } out_item_t;

  // Closing result of a burst, handed from the lexer to the emitter.
  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
    logic [7:0] ch;
  } tail_t;

  // Keywords are right-justified: the first letter sits in the highest used byte.
  localparam logic [8*KW_CHARS-1:0] KW_STR [KW_NUM] = '{
    "auto", "const", "double", "float", "int", "short", "struct", "unsigned",
    "break", "continue", "else", "for", "long", "signed", "switch", "void",
    "case", "default", "enum", "goto", "register", "sizeof", "typedef", "volatile",
    "char", "do", "extern", "if", "return", "static", "union", "while"
  };

  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd4, 4'd5, 4'd6, 4'd5, 4'd3, 4'd5, 4'd6, 4'd8,
    4'd5, 4'd8, 4'd4, 4'd3, 4'd4, 4'd6, 4'd6, 4'd4,
    4'd4, 4'd7, 4'd4, 4'd4, 4'd8, 4'd6, 4'd7, 4'd8,
    4'd4, 4'd2, 4'd6, 4'd2, 4'd6, 4'd6, 4'd5, 4'd5
  };

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    is_lower = (c >= "a" && c <= "z");
  endfunction

  // Letter j of keyword k, zero beyond the keyword's end.
  function automatic logic [7:0] kw_byte(input int k, input int j);
    int n;
    n = int'(KW_LEN[k]);
    if (j < n) begin
      kw_byte = KW_STR[k][8*(n-1-j) +: 8];
    end else begin
      kw_byte = 8'h00;
    end
  endfunction

endpackage

// ===== hdl/cku_kw_match.sv =====
// Keyword matcher: compares the held word against the keyword table in parallel.
// Depends on cku_pkg.
module cku_kw_match #(
  parameter int MAX_LEN  = 8,
  parameter int KW_COUNT = 32,
  localparam int LW = $clog2(MAX_LEN + 1)
) (
  input  logic [MAX_LEN-1:0][7:0] word,
  input  logic [LW-1:0]           len,
  output logic                    is_kw
);
  import cku_pkg::*;

  logic [KW_COUNT-1:0] hit;

  // Only letters below the keyword's length are compared; the length check
  // rules out any word of different size, so stale entries never matter.
  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      hit[k] = (len == LW'(KW_LEN[k]));
      for (int j = 0; j < KW_CHARS; j++) begin
        if (j < int'(KW_LEN[k]) && word[j] != kw_byte(k, j)) begin
          hit[k] = 1'b0;
        end
      end
    end
    is_kw = |hit;
  end

endmodule

// ===== hdl/cku_lexer.sv =====
// Lexer: mode register, held-word store and per-transfer decision of which
// letters to flush and which closing result to emit. Depends on cku_pkg.
module cku_lexer #(
  parameter int MAX_LEN  = 8,
  parameter int KW_COUNT = 32,
  localparam int LW = $clog2(MAX_LEN + 1),
  localparam int IW = $clog2(MAX_LEN)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    take,
  input  cku_pkg::in_item_t       item,
  output logic                    load,
  output logic [MAX_LEN-1:0][7:0] flush_bytes,
  output logic [LW-1:0]           flush_cnt,
  output cku_pkg::tail_t          tail
);
  import cku_pkg::*;

  lex_mode_t                mode_r, mode_nxt;
  logic [LW-1:0]            len_r, len_nxt;
  logic [MAX_LEN-1:0][7:0]  store_r;
  logic                     wr_en;
  logic [IW-1:0]            wr_idx;
  logic                     is_kw;
  logic                     upper;
  logic [7:0]               c;
  logic                     letter;
  logic                     txt_word;
  lex_mode_t                txt_mode;
  tail_t                    txt_tail;
  tail_t                    char_tail;

  cku_kw_match #(.MAX_LEN(MAX_LEN), .KW_COUNT(KW_COUNT)) u_match (
    .word  (store_r),
    .len   (len_r),
    .is_kw (is_kw)
  );

  always_comb begin
    c              = item.char_in;
    letter         = is_letter(c);
    char_tail.vld  = 1'b1;
    char_tail.kind = KIND_CHAR;
    char_tail.ch   = c;

    // Outcome of a byte seen in plain text: a letter opens a word, anything
    // else is echoed at once.
    txt_word = letter;
    txt_tail = letter ? '0 : char_tail;
    if (letter) begin
      txt_mode = MODE_WORD;
    end else if (c == CH_SLASH) begin
      txt_mode = MODE_SLASH;
    end else begin
      txt_mode = MODE_TEXT;
    end

    mode_nxt  = mode_r;
    len_nxt   = len_r;
    wr_en     = 1'b0;
    wr_idx    = '0;
    tail      = '0;
    flush_cnt = '0;
    upper     = 1'b0;

    if (item.end_in) begin
      if (mode_r == MODE_WORD) begin
        flush_cnt = len_r;
        upper     = is_kw;
      end
      tail.vld  = 1'b1;
      tail.kind = (mode_r == MODE_BLOCK || mode_r == MODE_BSTAR) ? KIND_END_OPEN
                                                                 : KIND_END_OK;
      tail.ch   = 8'h00;
      mode_nxt  = MODE_TEXT;
      len_nxt   = '0;
    end else begin
      unique case (mode_r)
        MODE_WORD: begin
          if (letter) begin
            if (len_r < LW'(MAX_LEN)) begin
              wr_en   = 1'b1;
              wr_idx  = len_r[IW-1:0];
              len_nxt = len_r + 1'b1;
            end else begin
              // Run too long to be a keyword: release it as it stands.
              flush_cnt = len_r;
              tail      = char_tail;
              mode_nxt  = MODE_PASS;
              len_nxt   = '0;
            end
          end else begin
            flush_cnt = len_r;
            upper     = is_kw;
            tail      = txt_tail;
            mode_nxt  = txt_mode;
            len_nxt   = '0;
          end
        end
        MODE_PASS: begin
          if (letter) begin
            tail = char_tail;
          end else begin
            tail     = txt_tail;
            mode_nxt = txt_mode;
          end
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            tail     = char_tail;
            mode_nxt = MODE_LINE;
          end else if (c == CH_STAR) begin
            tail     = char_tail;
            mode_nxt = MODE_BLOCK;
          end else begin
            tail     = txt_tail;
            mode_nxt = txt_mode;
            wr_en    = txt_word;
            len_nxt  = LW'(txt_word);
          end
        end
        MODE_LINE: begin
          tail = char_tail;
          if (c == CH_NEWLINE) begin
            mode_nxt = MODE_TEXT;
          end
        end
        MODE_BLOCK: begin
          tail = char_tail;
          if (c == CH_STAR) begin
            mode_nxt = MODE_BSTAR;
          end
        end
        MODE_BSTAR: begin
          tail = char_tail;
          if (c == CH_SLASH) begin
            mode_nxt = MODE_TEXT;
          end else if (c != CH_STAR) begin
            mode_nxt = MODE_BLOCK;
          end
        end
        default: begin
          tail     = txt_tail;
          mode_nxt = txt_mode;
          wr_en    = txt_word;
          len_nxt  = LW'(txt_word);
        end
      endcase
    end

    // Every transfer that yields results ends with exactly one closing result.
    load = take & tail.vld;

    for (int i = 0; i < MAX_LEN; i++) begin
      flush_bytes[i] = (upper && is_lower(store_r[i])) ? (store_r[i] - CASE_OFFSET)
                                                       : store_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TEXT;
      len_r  <= '0;
    end else if (take) begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && wr_en) begin
      store_r[wr_idx] <= c;
    end
  end

endmodule

// ===== hdl/cku_emitter.sv =====
// Emitter: result register that plays out a burst of flushed letters followed
// by its closing result, one per transfer. Depends on cku_pkg.
module cku_emitter #(
  parameter int MAX_LEN = 8,
  localparam int LW = $clog2(MAX_LEN + 1),
  localparam int IW = $clog2(MAX_LEN)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  logic [MAX_LEN-1:0][7:0] flush_bytes,
  input  logic [LW-1:0]           flush_cnt,
  input  cku_pkg::tail_t          tail,
  output logic                    ready,
  output logic                    out_valid,
  input  logic                    out_stall,
  output cku_pkg::out_item_t      out_item
);
  import cku_pkg::*;

  logic [MAX_LEN-1:0][7:0] bytes_r;
  logic [LW-1:0]           cnt_r;
  logic [LW-1:0]           pos_r;
  logic [1:0]              tail_kind_r;
  logic [7:0]              tail_ch_r;
  logic                    valid_r;
  logic                    in_word;
  logic                    fire;

  always_comb begin
    in_word   = (pos_r < cnt_r);
    fire      = valid_r & ~out_stall;
    out_valid = valid_r;
    if (in_word) begin
      out_item.kind     = KIND_CHAR;
      out_item.char_out = bytes_r[pos_r[IW-1:0]];
      out_item.last     = 1'b0;
    end else begin
      out_item.kind     = tail_kind_r;
      out_item.char_out = tail_ch_r;
      out_item.last     = 1'b1;
    end
    // Free when empty, or when the closing result leaves in this cycle.
    ready = ~valid_r | (fire & ~in_word);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
      pos_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      cnt_r   <= flush_cnt;
      pos_r   <= '0;
    end else if (fire) begin
      if (in_word) begin
        pos_r <= pos_r + 1'b1;
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r     <= flush_bytes;
      tail_kind_r <= tail.kind;
      tail_ch_r   <= tail.ch;
    end
  end

endmodule

// ===== hdl/c_keyword_uppercase_filter.sv =====
// C keyword upper-casing filter, top level. Depends on cku_pkg, cku_lexer, cku_emitter.
// The first result of a transfer is offered in the cycle after it is accepted.
// Throughput: one byte per cycle while no word is held and the receiver keeps up;
// a transfer that flushes n held letters gives n+1 results and stalls the input
// until the last leaves, as the emitter's result register plays them out one per cycle.
// Reset (rst_n low, synchronous) returns the lexer to text mode and empties the emitter.
module c_keyword_uppercase_filter #(
  parameter int KEYWORD_MAX_LEN = 8,
  parameter int KEYWORD_COUNT   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cku_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output cku_pkg::out_item_t out_item
);
  import cku_pkg::*;

  localparam int LW = $clog2(KEYWORD_MAX_LEN + 1);

  // The lexer holds the mode and the letters of a word that may still turn
  // out to be a keyword. On every accepted transfer it decides, in one pass of
  // logic, how many held letters are released (upper-cased when they spell a
  // keyword) and which single result closes the burst. A transfer that only
  // extends a word produces no result at all.
  //
  // The emitter registers that burst and hands it out one transfer at a time.
  // A new input is taken whenever the emitter is empty or its closing result
  // is leaving in the same cycle, so a plain character stream runs at one
  // byte per cycle while the receiver keeps up.

  logic                            take;
  logic                            load;
  logic                            ready;
  logic [KEYWORD_MAX_LEN-1:0][7:0] flush_bytes;
  logic [LW-1:0]                   flush_cnt;
  tail_t                           tail;

  assign in_stall = ~ready;
  assign take     = in_valid & ~in_stall;

  cku_lexer #(
    .MAX_LEN  (KEYWORD_MAX_LEN),
    .KW_COUNT (KEYWORD_COUNT)
  ) u_lexer (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .item        (in_item),
    .load        (load),
    .flush_bytes (flush_bytes),
    .flush_cnt   (flush_cnt),
    .tail        (tail)
  );

  cku_emitter #(
    .MAX_LEN (KEYWORD_MAX_LEN)
  ) u_emitter (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (load),
    .flush_bytes (flush_bytes),
    .flush_cnt   (flush_cnt),
    .tail        (tail),
    .ready       (ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

// ===== hdl/cku_checker.sv =====
// Port-level checker for the keyword filter and the bind that attaches it.
// Depends on cku_pkg and c_keyword_uppercase_filter.
module cku_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input cku_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input cku_pkg::out_item_t out_item
);
  import cku_pkg::*;

  // A result that is stalled stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_item))
    else $error("result payload changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // An end status always closes its burst and carries no character.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind != KIND_CHAR |-> out_item.last && out_item.char_out == 8'h00)
    else $error("end status not final or not zero");

  // A stalled input transfer stays offered with the same payload.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("input withdrawn or changed while stalled");

endmodule

bind c_keyword_uppercase_filter cku_checker u_cku_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== tb/sv/c_keyword_uppercase_filter_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the C keyword upper-casing filter: a stimulus table, then
// random source text, each result checked against a typed value or an in-bench lexer model.
// Depends on cku_pkg and c_keyword_uppercase_filter.
module c_keyword_uppercase_filter_tb;
  import cku_pkg::*;

  localparam int WORD_MAX  = 8;       // longest run of letters that is still held back
  localparam int RUN_LIMIT = 200000;  // clock cycles before the run is declared hung
  localparam int PHASE_LEN = 145;     // random transfers offered in each idling phase
  localparam int JAM_LEN   = 120;     // cycles the receiver holds off in one stretch

  // Clock and reset. All inputs change at the falling edge; outputs are sampled at the
  // rising edge.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  c_keyword_uppercase_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // The thirty-two keywords, in lower case, as the lexer must recognise them.
  string c_keywords [32] = '{
    "auto", "const", "double", "float", "int", "short", "struct", "unsigned",
    "break", "continue", "else", "for", "long", "signed", "switch", "void",
    "case", "default", "enum", "goto", "register", "sizeof", "typedef", "volatile",
    "char", "do", "extern", "if", "return", "static", "union", "while"
  };

  // Lexer model state: the mode, the letters held back and how many there are.
  lex_mode_t  lx_mode = MODE_TEXT;
  logic [7:0] held [WORD_MAX];
  int         held_n  = 0;

  out_item_t  burst_q  [$];  // results caused by the transfer being predicted
  out_item_t  echo_due [$];  // results still owed by the block, oldest first
  out_item_t  head;
  int         mismatches = 0;
  int         cycle_cnt  = 0;

  // Idling rates in percent. The receiver's rate is read at the falling edge, so it is
  // only ever changed by a nonblocking assignment.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // The long hold-off of the receiver is timed in a process of its own.
  bit jam_req = 1'b0;
  bit jam_on  = 1'b0;

  // Side information travelling with each offered transfer: whether its result was typed
  // into the stimulus table, and if so what that result is.
  bit        offer_typed = 1'b0;
  out_item_t offer_want  = '0;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } table_row_t;

  table_row_t dir_rows [$];
  in_item_t   stim_q   [$];

  // ------------------------------------------------------------------------------------
  // Lexer model
  // ------------------------------------------------------------------------------------

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void push_echo(input logic [1:0] kind, input logic [7:0] c);
    out_item_t r;
    r.kind     = kind;
    r.char_out = c;
    r.last     = 1'b0;
    burst_q.push_back(r);
  endfunction

  // Matching is case sensitive, so only the lower-case spelling of a keyword counts.
  function automatic bit held_is_keyword();
    bit hit;
    bit same;
    int k;
    int j;
    hit = 1'b0;
    for (k = 0; k < 32; k++) begin
      if (c_keywords[k].len() == held_n) begin
        same = 1'b1;
        for (j = 0; j < held_n; j++) begin
          if (held[j] != 8'(c_keywords[k][j])) same = 1'b0;
        end
        if (same) hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic void flush_held(input bit check);
    bit         up;
    int         i;
    logic [7:0] c;
    up = check && held_is_keyword();
    for (i = 0; i < held_n; i++) begin
      c = held[i];
      if (up && c >= "a" && c <= "z") c = c - CASE_OFFSET;
      push_echo(KIND_CHAR, c);
    end
    held_n = 0;
  endfunction

  // A byte met in plain text: a letter opens a word, a slash may open a comment.
  function automatic void start_text(input logic [7:0] c);
    if (is_alpha(c)) begin
      held[0] = c;
      held_n  = 1;
      lx_mode = MODE_WORD;
    end else if (c == CH_SLASH) begin
      push_echo(KIND_CHAR, c);
      lx_mode = MODE_SLASH;
    end else begin
      push_echo(KIND_CHAR, c);
      lx_mode = MODE_TEXT;
    end
  endfunction

  // Works out the results of one accepted transfer into burst_q and moves the model on.
  function automatic void predict_echo(input in_item_t it);
    logic [7:0] c;
    c = it.char_in;
    burst_q.delete();
    if (it.end_in) begin
      // The end marker flushes a held word, then reports whether a block comment was
      // left open, and everything returns to its state after reset.
      if (lx_mode == MODE_WORD) flush_held(1'b1);
      if (lx_mode == MODE_BLOCK || lx_mode == MODE_BSTAR) begin
        push_echo(KIND_END_OPEN, 8'h00);
      end else begin
        push_echo(KIND_END_OK, 8'h00);
      end
      lx_mode = MODE_TEXT;
      held_n  = 0;
    end else begin
      case (lx_mode)
        MODE_WORD: begin
          if (is_alpha(c)) begin
            if (held_n < WORD_MAX) begin
              held[held_n] = c;
              held_n++;
            end else begin
              // Too long for a keyword: out it goes unchanged, and so does the rest.
              flush_held(1'b0);
              push_echo(KIND_CHAR, c);
              lx_mode = MODE_PASS;
            end
          end else begin
            flush_held(1'b1);
            start_text(c);
          end
        end
        MODE_PASS: begin
          if (is_alpha(c)) begin
            push_echo(KIND_CHAR, c);
          end else begin
            start_text(c);
          end
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            push_echo(KIND_CHAR, c);
            lx_mode = MODE_LINE;
          end else if (c == CH_STAR) begin
            push_echo(KIND_CHAR, c);
            lx_mode = MODE_BLOCK;
          end else begin
            // A lone slash has been echoed already; this byte is seen as plain text.
            start_text(c);
          end
        end
        MODE_LINE: begin
          push_echo(KIND_CHAR, c);
          if (c == CH_NEWLINE) lx_mode = MODE_TEXT;
        end
        MODE_BLOCK: begin
          push_echo(KIND_CHAR, c);
          if (c == CH_STAR) lx_mode = MODE_BSTAR;
        end
        MODE_BSTAR: begin
          push_echo(KIND_CHAR, c);
          if (c == CH_SLASH) begin
            lx_mode = MODE_TEXT;
          end else if (c != CH_STAR) begin
            lx_mode = MODE_BLOCK;
          end
        end
        default: begin
          start_text(c);
        end
      endcase
    end
    if (burst_q.size() > 0) burst_q[burst_q.size() - 1].last = 1'b1;
  endfunction

  // ------------------------------------------------------------------------------------
  // Stimulus construction
  // ------------------------------------------------------------------------------------

  function automatic in_item_t mk_item(input logic [7:0] c, input logic fin);
    in_item_t it;
    it.char_in = c;
    it.end_in  = fin;
    return it;
  endfunction

  function automatic void add_row(input logic [7:0] c, input logic fin);
    table_row_t r;
    r.stim  = mk_item(c, fin);
    r.typed = 1'b0;
    r.want  = '0;
    dir_rows.push_back(r);
  endfunction

  // A row whose single result is written out by hand.
  function automatic void add_checked(input logic [7:0] c, input logic fin,
                                      input logic [1:0] kind, input logic [7:0] ch_out);
    table_row_t r;
    r.stim          = mk_item(c, fin);
    r.typed         = 1'b1;
    r.want.kind     = kind;
    r.want.char_out = ch_out;
    r.want.last     = 1'b1;
    dir_rows.push_back(r);
  endfunction

  function automatic void put_byte(input logic [7:0] c);
    stim_q.push_back(mk_item(c, 1'b0));
  endfunction

  function automatic void put_end();
    // The byte that travels with an end marker is ignored, so it is left random.
    stim_q.push_back(mk_item(8'($urandom), 1'b1));
  endfunction

  function automatic logic [7:0] any_letter();
    logic [7:0] base;
    base = ($urandom_range(1) == 0) ? 8'("a") : 8'("A");
    return base + 8'($urandom_range(25));
  endfunction

  // Something that ends a word: mostly the usual punctuation, sometimes any non-letter.
  function automatic logic [7:0] any_sep();
    logic [7:0] c;
    case ($urandom_range(7))
      0: c = " ";
      1: c = CH_NEWLINE;
      2: c = "(";
      3: c = ";";
      4: c = CH_SLASH;
      5: c = CH_STAR;
      6: c = ",";
      default: begin
        do c = 8'($urandom); while (is_alpha(c));
      end
    endcase
    return c;
  endfunction

  // Appends one fragment of source text. Most fragments are well formed, so that words,
  // keywords and both kinds of comment are reached often; the rest is noise.
  function automatic void add_fragment();
    int         r;
    int         n;
    int         i;
    int         twist;
    string      w;
    logic [7:0] c;
    r = $urandom_range(99);
    if (r < 25) begin
      // A keyword, now and then spoilt by a capital or a trailing letter.
      w     = c_keywords[$urandom_range(31)];
      twist = $urandom_range(5);
      for (i = 0; i < w.len(); i++) begin
        c = 8'(w[i]);
        if (twist == 0 && i == 0) c = c - CASE_OFFSET;
        put_byte(c);
      end
      if (twist == 1) put_byte(any_letter());
      if ($urandom_range(9) == 0) begin
        put_end();
      end else begin
        put_byte(any_sep());
      end
    end else if (r < 45) begin
      // An ordinary identifier; a few are long enough to spill over the word store.
      n = ($urandom_range(6) == 0) ? $urandom_range(14, 9) : $urandom_range(8, 1);
      for (i = 0; i < n; i++) put_byte(any_letter());
      put_byte(any_sep());
    end else if (r < 55) begin
      put_byte(CH_SLASH);
      put_byte(CH_SLASH);
      n = $urandom_range(5);
      for (i = 0; i < n; i++) put_byte(8'($urandom));
      put_byte(CH_NEWLINE);
    end else if (r < 67) begin
      // A block comment with stray stars and slashes inside; one in eight is left open.
      put_byte(CH_SLASH);
      put_byte(CH_STAR);
      n = $urandom_range(6);
      for (i = 0; i < n; i++) begin
        case ($urandom_range(3))
          0: put_byte(CH_STAR);
          1: put_byte(CH_SLASH);
          default: put_byte(8'($urandom));
        endcase
      end
      if ($urandom_range(7) != 0) begin
        put_byte(CH_STAR);
        put_byte(CH_SLASH);
      end
    end else if (r < 75) begin
      put_byte(CH_SLASH);
      if ($urandom_range(1) == 0) begin
        put_byte(any_letter());
      end else begin
        put_byte(8'($urandom));
      end
    end else if (r < 90) begin
      n = $urandom_range(3, 1);
      for (i = 0; i < n; i++) put_byte(8'($urandom));
    end else if (r < 96) begin
      put_byte(any_sep());
    end else begin
      put_end();
    end
  endfunction

  // ------------------------------------------------------------------------------------
  // Driving
  // ------------------------------------------------------------------------------------

  // Offers one transfer, starting and ending at a falling edge. Valid is left high on
  // return so that back-to-back transfers never lower and raise it in the same step.
  task automatic offer(input in_item_t it, input bit typed, input out_item_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_item     <= it;
    offer_typed <= typed;
    offer_want  <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // The sender pauses until the block has delivered every result it owes.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (echo_due.size() != 0);
  endtask

  // The receiver stalls at random, or solidly while the long hold-off runs.
  always @(negedge clk) begin
    if (jam_on) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    wait (jam_req);
    @(posedge clk);
    jam_on = 1'b1;
    repeat (JAM_LEN) @(posedge clk);
    jam_on = 1'b0;
  end

  // ------------------------------------------------------------------------------------
  // Checking at the rising edge
  // ------------------------------------------------------------------------------------

  // Outputs are checked before the input transfer of the same edge is predicted, since
  // a transfer cannot produce its first result at the edge at which it is accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (echo_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: kind %0d char %02h last %0b",
                     out_item.kind, out_item.char_out, out_item.last);
          end
        end else begin
          head = echo_due.pop_front();
          if (out_item.kind !== head.kind || out_item.char_out !== head.char_out ||
              out_item.last !== head.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp kind %0d ch %02h last %0b, got kind %0d ch %02h last %0b",
                       head.kind, head.char_out, head.last,
                       out_item.kind, out_item.char_out, out_item.last);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_echo(in_item);
        if (offer_typed) begin
          echo_due.push_back(offer_want);
        end else begin
          foreach (burst_q[i]) echo_due.push_back(burst_q[i]);
        end
      end
    end
  end

  // Watchdog against a block that hangs or loses a result.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ------------------------------------------------------------------------------------
  // Sequence of the run
  // ------------------------------------------------------------------------------------

  initial begin
    int ph;
    int i;

    // Stimulus table. Rows with a typed result are the ones whose answer is plain at a
    // glance; the others are left to the lexer model.
    add_checked(8'h00, 1'b1, KIND_END_OK, 8'h00);   // end marker straight after reset
    add_checked(8'h00, 1'b0, KIND_CHAR, 8'h00);     // lowest byte in plain text
    add_row("i", 1'b0);                             // a keyword closed by the end marker
    add_row("n", 1'b0);
    add_row("t", 1'b0);
    add_row(8'hff, 1'b1);
    add_row("A", 1'b0);                             // nine letters: spills over the store
    add_row("Z", 1'b0);
    add_row("a", 1'b0);
    add_row("z", 1'b0);
    add_row("u", 1'b0);
    add_row("n", 1'b0);
    add_row("s", 1'b0);
    add_row("i", 1'b0);
    add_row("g", 1'b0);
    add_row(CH_SLASH, 1'b0);                        // lone slash after a passed-through run
    add_row("a", 1'b0);                             // a letter after it opens a word
    add_row(CH_SLASH, 1'b0);                        // which ends at the next slash
    add_row(CH_SLASH, 1'b0);                        // line comment
    add_checked(8'hff, 1'b0, KIND_CHAR, 8'hff);     // highest byte inside the comment
    add_row(CH_NEWLINE, 1'b0);
    add_row(CH_SLASH, 1'b0);                        // block comment, star, then no slash
    add_row(CH_STAR, 1'b0);
    add_row(CH_STAR, 1'b0);
    add_row("x", 1'b0);
    add_checked(8'h00, 1'b1, KIND_END_OPEN, 8'h00); // end with the comment still open

    // Reset is held low from the start and released at a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n          <= 1'b1;
    send_idle_pct   = 33;
    recv_stall_pct <= 69;

    foreach (dir_rows[i]) offer(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    drain();

    // Three random phases: the sender idles more lightly, then more heavily, than the
    // receiver stalls, and finally neither side idles. The last phase also carries the
    // long hold-off, during which the block fills up and stalls its input.
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct   = 33;
          recv_stall_pct <= 69;
        end
        1: begin
          send_idle_pct   = 69;
          recv_stall_pct <= 33;
        end
        default: begin
          send_idle_pct   = 0;
          recv_stall_pct <= 0;
          jam_req         = 1'b1;
        end
      endcase
      stim_q.delete();
      while (stim_q.size() < PHASE_LEN) add_fragment();
      put_end();
      for (i = 0; i < stim_q.size(); i++) offer(stim_q[i], 1'b0, '0);
      drain();
    end

    // Everything owed has arrived; the bench idles once more before its verdict, to show
    // that the block produces nothing further.
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
